@@ rtl/tpmf_pkg.sv @@
// Shared types, register codes and constants for the touch point transform filter.
`timescale 1ns / 1ps

package tpmf_pkg;

  localparam int COORD_BITS = 12;
  localparam int NIB_BITS   = 4;
  localparam int BYTE_BITS  = 8;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int HIST_DEPTH = 3;
  localparam int DIV_STEPS  = COORD_BITS;

  typedef logic [COORD_BITS-1:0]              coord_t;
  typedef logic [NIB_BITS-1:0]                nib_t;
  typedef logic [BYTE_BITS-1:0]               byte_t;
  typedef logic [1:0]                         hcnt_t;
  typedef logic [2:0]                         reg_idx_t;
  typedef logic [$clog2(DIV_STEPS+1)-1:0]     dcnt_t;

  localparam reg_idx_t REG_DISPLAY_WIDTH  = 3'd0;
  localparam reg_idx_t REG_DISPLAY_HEIGHT = 3'd1;
  localparam reg_idx_t REG_PANEL_WIDTH    = 3'd2;
  localparam reg_idx_t REG_PANEL_HEIGHT   = 3'd3;
  localparam reg_idx_t REG_SWAP_AXES      = 3'd4;
  localparam reg_idx_t REG_FLIP_X         = 3'd5;
  localparam reg_idx_t REG_FLIP_Y         = 3'd6;

  typedef struct packed {
    coord_t display_width;
    coord_t display_height;
    coord_t panel_width;
    coord_t panel_height;
    logic   swap_axes;
    logic   flip_x;
    logic   flip_y;
  } cfg_t;

  typedef struct packed {
    logic  bus_error;
    byte_t status_byte;
    byte_t x_high_byte;
    byte_t x_low_byte;
    byte_t y_high_byte;
    byte_t y_low_byte;
  } in_item_t;

  typedef struct packed {
    logic   touch_valid;
    coord_t pos_x;
    coord_t pos_y;
    nib_t   touch_tag;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic div_start;
    logic div_sel_y;
    logic take;
    logic push;
    logic filter;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic scale_x;
    logic scale_y;
    logic div_done;
    logic div_busy;
    logic out_free;
  } dp_sta_t;

endpackage

@@ rtl/tpmf_if.sv @@
// Valid/ready channel interfaces for touch reports and filtered points.
`timescale 1ns / 1ps

interface tpmf_in_if;
  logic                valid;
  logic                ready;
  logic                bus_error;
  tpmf_pkg::byte_t     status_byte;
  tpmf_pkg::byte_t     x_high_byte;
  tpmf_pkg::byte_t     x_low_byte;
  tpmf_pkg::byte_t     y_high_byte;
  tpmf_pkg::byte_t     y_low_byte;

  modport source (output valid, bus_error, status_byte, x_high_byte, x_low_byte,
                  y_high_byte, y_low_byte, input ready);
  modport sink   (input valid, bus_error, status_byte, x_high_byte, x_low_byte,
                  y_high_byte, y_low_byte, output ready);
endinterface

interface tpmf_out_if;
  logic                valid;
  logic                ready;
  logic                touch_valid;
  tpmf_pkg::coord_t    pos_x;
  tpmf_pkg::coord_t    pos_y;
  tpmf_pkg::nib_t      touch_tag;

  modport source (output valid, touch_valid, pos_x, pos_y, touch_tag, input ready);
  modport sink   (input valid, touch_valid, pos_x, pos_y, touch_tag, output ready);
endinterface

@@ rtl/tpmf_div.sv @@
// Shared multiply then restoring divide unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module tpmf_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tpmf_pkg::coord_t mul_a,
  input  tpmf_pkg::coord_t mul_b,
  input  tpmf_pkg::coord_t divisor,
  output logic             busy,
  output logic             done,
  output tpmf_pkg::coord_t quotient
);

  localparam int W = tpmf_pkg::COORD_BITS;

  logic [2*W-1:0]        prod;
  logic [W-1:0]          rem_r, rem_nxt;
  logic [W-1:0]          quo_r;
  logic [W-1:0]          dsr_r;
  logic [W:0]            trial;
  logic [W:0]            diff;
  logic                  ge;
  tpmf_pkg::dcnt_t       cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // The product never reaches divisor << W, so the upper half seeds the remainder
  // and only W quotient bits are needed.
  assign prod    = (2*W)'(mul_a) * (2*W)'(mul_b);
  assign trial   = {rem_r, quo_r[W-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign ge      = (trial >= {1'b0, dsr_r});
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tpmf_pkg::dcnt_t'(tpmf_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - tpmf_pkg::dcnt_t'(1);
        if (cnt_r == tpmf_pkg::dcnt_t'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= prod[2*W-1:W];
      quo_r <= prod[W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/tpmf_dp.sv @@
// Datapath: report decode, clamp/swap/mirror, scaling, history, filter and output register.
`timescale 1ns / 1ps

module tpmf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tpmf_pkg::cfg_t      cfg,
  input  tpmf_pkg::dp_cmd_t   cmd,
  input  tpmf_pkg::in_item_t  in_item,
  input  logic                out_ready,
  output tpmf_pkg::dp_sta_t   sta,
  output logic                out_valid,
  output tpmf_pkg::out_item_t out_item
);

  localparam int W = tpmf_pkg::COORD_BITS;

  function automatic tpmf_pkg::coord_t min2(tpmf_pkg::coord_t a, tpmf_pkg::coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic tpmf_pkg::coord_t max2(tpmf_pkg::coord_t a, tpmf_pkg::coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic tpmf_pkg::coord_t med3(tpmf_pkg::coord_t a, tpmf_pkg::coord_t b,
                                            tpmf_pkg::coord_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  localparam tpmf_pkg::coord_t ONE = tpmf_pkg::coord_t'(1);

  // Decode and geometry, evaluated on the incoming report and captured with it
  tpmf_pkg::coord_t raw_x, raw_y, xc, yc, xs, ys, rx, ry, xf, yf;
  logic             en, scx, scy;

  // Item registers
  logic             err_r, zero_r, en_r, scx_r, scy_r;
  tpmf_pkg::coord_t x_r, y_r, rx_r, ry_r;
  tpmf_pkg::nib_t   id_r;

  // Divider
  tpmf_pkg::coord_t div_a, div_b, div_d, div_q;
  logic             div_busy, div_done;

  // History and filter
  tpmf_pkg::coord_t hx_r [tpmf_pkg::HIST_DEPTH];
  tpmf_pkg::coord_t hy_r [tpmf_pkg::HIST_DEPTH];
  tpmf_pkg::hcnt_t  hcnt_r;
  tpmf_pkg::coord_t xfin, yfin;
  logic [W:0]       sum_x, sum_y;
  tpmf_pkg::coord_t filt_x, filt_y, res_x_r, res_y_r;

  // Output register
  logic                out_valid_r;
  tpmf_pkg::out_item_t out_item_r;
  logic                out_free;
  logic                ok;

  assign raw_x = {in_item.x_high_byte[tpmf_pkg::NIB_BITS-1:0], in_item.x_low_byte};
  assign raw_y = {in_item.y_high_byte[tpmf_pkg::NIB_BITS-1:0], in_item.y_low_byte};

  assign en = (cfg.display_width != '0) && (cfg.display_height != '0) &&
              (cfg.panel_width != '0) && (cfg.panel_height != '0);

  always_comb begin
    xc = (raw_x >= cfg.panel_width)  ? cfg.panel_width - ONE  : raw_x;
    yc = (raw_y >= cfg.panel_height) ? cfg.panel_height - ONE : raw_y;
    if (cfg.swap_axes) begin
      xs = yc;
      ys = xc;
      rx = cfg.panel_height;
      ry = cfg.panel_width;
    end else begin
      xs = xc;
      ys = yc;
      rx = cfg.panel_width;
      ry = cfg.panel_height;
    end
    // With nonzero ranges the clamp keeps the point in range, so no mirror underflows.
    xf  = cfg.flip_x ? (rx - ONE) - xs : xs;
    yf  = cfg.flip_y ? (ry - ONE) - ys : ys;
    scx = en && (cfg.display_width > ONE) && (rx > ONE) && (cfg.display_width != rx);
    scy = en && (cfg.display_height > ONE) && (ry > ONE) && (cfg.display_height != ry);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= 1'b0;
      zero_r <= 1'b0;
    end else if (cmd.capture) begin
      err_r  <= in_item.bus_error;
      zero_r <= (in_item.status_byte[tpmf_pkg::NIB_BITS-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= en ? xf : raw_x;
      y_r   <= en ? yf : raw_y;
      rx_r  <= rx;
      ry_r  <= ry;
      en_r  <= en;
      scx_r <= scx;
      scy_r <= scy;
      id_r  <= in_item.y_high_byte[tpmf_pkg::BYTE_BITS-1:tpmf_pkg::NIB_BITS];
    end else if (cmd.take) begin
      if (cmd.div_sel_y) begin
        y_r <= div_q;
      end else begin
        x_r <= div_q;
      end
    end
  end

  assign div_a = cmd.div_sel_y ? y_r : x_r;
  assign div_b = cmd.div_sel_y ? cfg.display_height - ONE : cfg.display_width - ONE;
  assign div_d = cmd.div_sel_y ? ry_r - ONE : rx_r - ONE;

  tpmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .mul_a    (div_a),
    .mul_b    (div_b),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Final clamp to the display range
  assign xfin = (en_r && (x_r >= cfg.display_width))  ? cfg.display_width - ONE  : x_r;
  assign yfin = (en_r && (y_r >= cfg.display_height)) ? cfg.display_height - ONE : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
    end else if (cmd.clear) begin
      hcnt_r <= '0;
    end else if (cmd.push && (hcnt_r != 2'd3)) begin
      hcnt_r <= hcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (hcnt_r == 2'd3) begin
        for (int i = 0; i < tpmf_pkg::HIST_DEPTH - 1; i++) begin
          hx_r[i] <= hx_r[i+1];
          hy_r[i] <= hy_r[i+1];
        end
        hx_r[tpmf_pkg::HIST_DEPTH-1] <= xfin;
        hy_r[tpmf_pkg::HIST_DEPTH-1] <= yfin;
      end else begin
        for (int i = 0; i < tpmf_pkg::HIST_DEPTH; i++) begin
          if (hcnt_r == tpmf_pkg::hcnt_t'(i)) begin
            hx_r[i] <= xfin;
            hy_r[i] <= yfin;
          end
        end
      end
    end
  end

  assign sum_x = {1'b0, hx_r[0]} + {1'b0, hx_r[1]};
  assign sum_y = {1'b0, hy_r[0]} + {1'b0, hy_r[1]};

  always_comb begin
    unique case (hcnt_r)
      2'd1: begin
        filt_x = hx_r[0];
        filt_y = hy_r[0];
      end
      2'd2: begin
        filt_x = sum_x[W:1];
        filt_y = sum_y[W:1];
      end
      2'd3: begin
        filt_x = med3(hx_r[0], hx_r[1], hx_r[2]);
        filt_y = med3(hy_r[0], hy_r[1], hy_r[2]);
      end
      default: begin
        filt_x = '0;
        filt_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.filter) begin
      res_x_r <= filt_x;
      res_y_r <= filt_y;
    end
  end

  assign ok       = !err_r && !zero_r;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.touch_valid <= ok;
      out_item_r.pos_x       <= ok ? res_x_r : '0;
      out_item_r.pos_y       <= ok ? res_y_r : '0;
      out_item_r.touch_tag   <= ok ? id_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sta          = '0;
    sta.err      = err_r;
    sta.zero     = zero_r;
    sta.scale_x  = scx_r;
    sta.scale_y  = scy_r;
    sta.div_done = div_done;
    sta.div_busy = div_busy;
    sta.out_free = out_free;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> ok)
    else $error("history written for a report without a touch");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (!div_busy && $past(div_busy)))
    else $error("divider done without a finished division");

endmodule

@@ rtl/tpmf_ctrl.sv @@
// Controller state machine sequencing one report through the datapath.
`timescale 1ns / 1ps

module tpmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tpmf_pkg::dp_sta_t sta,
  output logic              in_ready,
  output tpmf_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DX     = 4'd2;
  localparam logic [3:0] S_DXW    = 4'd3;
  localparam logic [3:0] S_DY     = 4'd4;
  localparam logic [3:0] S_DYW    = 4'd5;
  localparam logic [3:0] S_PUSH   = 4'd6;
  localparam logic [3:0] S_FILT   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sta.err) begin
          state_nxt = S_FINISH;
        end else if (sta.zero) begin
          cmd.clear = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        cmd.div_start = sta.scale_x;
        state_nxt     = sta.scale_x ? S_DXW : S_DY;
      end
      S_DXW: begin
        cmd.take = sta.div_done;
        if (sta.div_done) begin
          state_nxt = S_DY;
        end
      end
      S_DY: begin
        cmd.div_sel_y = 1'b1;
        cmd.div_start = sta.scale_y;
        state_nxt     = sta.scale_y ? S_DYW : S_PUSH;
      end
      S_DYW: begin
        cmd.div_sel_y = 1'b1;
        cmd.take      = sta.div_done;
        if (sta.div_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_FILT;
      end
      S_FILT: begin
        cmd.filter = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit = sta.out_free;
        if (sta.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/touch_point_transform_median_filter_top.sv @@
// One item is in flight at a time: a report is taken only after the last one has gone to
// the result register. A bus error or no-touch report goes from decode to the result
// register; a touch runs a division for each scaled axis, one after the other on one
// shared bit-serial divider, twelve quotient bits each.
// Reset (synchronous, active low) clears the configuration registers to zero, empties the
// touch history and the result register, and leaves the block ready for an item.
`timescale 1ns / 1ps

module touch_point_transform_median_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  tpmf_in_if.sink                      in_chan,
  tpmf_out_if.source                   out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tpmf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tpmf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tpmf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  // The configuration registers live here; the datapath reads them directly throughout an
  // item, so they must be written only while the block is idle, which it does not enforce.
  tpmf_pkg::cfg_t      cfg_r;
  tpmf_pkg::reg_idx_t  cfg_idx;
  logic                cfg_wr;

  tpmf_pkg::in_item_t  in_item;
  tpmf_pkg::out_item_t out_item;
  tpmf_pkg::dp_cmd_t   cmd;
  tpmf_pkg::dp_sta_t   sta;
  logic                in_ready;
  logic                out_valid;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[tpmf_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // A write to an address beyond the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tpmf_pkg::REG_DISPLAY_WIDTH:
          cfg_r.display_width  <= cfg_pwdata[tpmf_pkg::COORD_BITS-1:0];
        tpmf_pkg::REG_DISPLAY_HEIGHT:
          cfg_r.display_height <= cfg_pwdata[tpmf_pkg::COORD_BITS-1:0];
        tpmf_pkg::REG_PANEL_WIDTH:
          cfg_r.panel_width    <= cfg_pwdata[tpmf_pkg::COORD_BITS-1:0];
        tpmf_pkg::REG_PANEL_HEIGHT:
          cfg_r.panel_height   <= cfg_pwdata[tpmf_pkg::COORD_BITS-1:0];
        tpmf_pkg::REG_SWAP_AXES: cfg_r.swap_axes <= cfg_pwdata[0];
        tpmf_pkg::REG_FLIP_X:    cfg_r.flip_x    <= cfg_pwdata[0];
        tpmf_pkg::REG_FLIP_Y:    cfg_r.flip_y    <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tpmf_pkg::REG_DISPLAY_WIDTH:  cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.display_width);
      tpmf_pkg::REG_DISPLAY_HEIGHT: cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.display_height);
      tpmf_pkg::REG_PANEL_WIDTH:    cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.panel_width);
      tpmf_pkg::REG_PANEL_HEIGHT:   cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.panel_height);
      tpmf_pkg::REG_SWAP_AXES:      cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.swap_axes);
      tpmf_pkg::REG_FLIP_X:         cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.flip_x);
      tpmf_pkg::REG_FLIP_Y:         cfg_prdata = tpmf_pkg::CFG_DW'(cfg_r.flip_y);
      default:                      cfg_prdata = '0;
    endcase
  end

  // The report bytes are gathered into one item for the datapath, which captures them
  // on the cycle the controller accepts the item.
  always_comb begin
    in_item.bus_error   = in_chan.bus_error;
    in_item.status_byte = in_chan.status_byte;
    in_item.x_high_byte = in_chan.x_high_byte;
    in_item.x_low_byte  = in_chan.x_low_byte;
    in_item.y_high_byte = in_chan.y_high_byte;
    in_item.y_low_byte  = in_chan.y_low_byte;
  end

  assign in_chan.ready = in_ready;

  // The controller steps a touch through decode, a division per scaled axis, the history
  // update, the filter and the hand-over; other reports go from decode to the hand-over.
  tpmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sta      (sta),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // The datapath holds the item, the divider, the three-deep history and the result
  // register, which keeps a finished item while the next report is taken in.
  tpmf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_ready (out_chan.ready),
    .sta       (sta),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.touch_valid = out_item.touch_valid;
  assign out_chan.pos_x       = out_item.pos_x;
  assign out_chan.pos_y       = out_item.pos_y;
  assign out_chan.touch_tag   = out_item.touch_tag;

endmodule
